### rtl/lmfsd_pkg.sv
// Package for the LED matrix frame scan driver.
// Holds the command codes, controller states and fixed field widths.
// No dependencies.
`default_nettype none

package lmfsd_pkg;

  // Frame geometry and field widths
  localparam int unsigned LMFSD_SIDE   = 16;
  localparam int unsigned LMFSD_ROW_W  = 16;
  localparam int unsigned LMFSD_COORD_W = 4;
  localparam int unsigned LMFSD_WORD_W = 32;
  localparam int unsigned LMFSD_IN_W   = 16;
  localparam int unsigned LMFSD_OUT_W  = 40;

  // Command codes
  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_RENDER = 2'd3
  } lmfsd_cmd_e;

  // Result kinds
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_ROW   = 1'b1
  } lmfsd_kind_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_WRITE  = 2'd1,
    ST_READ   = 2'd2,
    ST_RENDER = 2'd3
  } lmfsd_state_e;

endpackage

`default_nettype wire

### rtl/led_matrix_frame_scan_driver_core.sv
// A write is accepted, then written back in ST_WRITE; a read answer enters the output
// register from ST_READ when the output is free; a render reads each row word, then loads it,
// one per cycle while the output is not stalled, paced by the single frame read port.
// Commands are taken one at a time; a clear is done at accept. Reset is asynchronous, active
// low; per-row valid flags make the frame read all-off after reset, with no clearing pass.
// Depends on lmfsd_pkg.
`default_nettype none

module led_matrix_frame_scan_driver_core
  import lmfsd_pkg::*;
#(
  parameter int unsigned Side = LMFSD_SIDE
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Command words
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [1:0] command, [5:2] x, [9:6] y, [10] pixel_on, [15:11] zero
  input  wire logic [LMFSD_IN_W-1:0]  s_axis_tdata_i,
  // Result words
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [0] pixel_value, [4:1] row_index, [36:5] shift_word, [39:37] zero
  output logic [LMFSD_OUT_W-1:0]      m_axis_tdata_o,
  // [0] kind
  output logic                        m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);

  localparam int unsigned AddrW = $clog2(Side);
  localparam logic [AddrW-1:0] LastRow = AddrW'(Side - 1);

  // Input field decode
  lmfsd_cmd_e               in_cmd;
  logic [LMFSD_COORD_W-1:0] in_x;
  logic [LMFSD_COORD_W-1:0] in_y;
  logic                     in_on;

  assign in_cmd = lmfsd_cmd_e'(s_axis_tdata_i[1:0]);
  assign in_x   = s_axis_tdata_i[5:2];
  assign in_y   = s_axis_tdata_i[9:6];
  assign in_on  = s_axis_tdata_i[10];

  // State
  lmfsd_state_e state_q, state_d;

  logic [AddrW-1:0]         x_q;
  logic [LMFSD_COORD_W-1:0] y_q;
  logic                     on_q;

  logic [Side-1:0]          row_vld_q;
  logic                     rd_vld_q;
  logic [LMFSD_ROW_W-1:0]   rd_data_q;
  logic [LMFSD_ROW_W-1:0]   mem [Side];

  logic [AddrW-1:0]         rd_row_q;
  logic                     rd_busy_q;
  logic                     pend_q;
  logic [AddrW-1:0]         ld_row_q;

  logic                     out_valid_q;
  lmfsd_kind_e              out_kind_q;
  logic                     out_pix_q;
  logic [LMFSD_COORD_W-1:0] out_row_q;
  logic [LMFSD_WORD_W-1:0]  out_word_q;
  logic                     out_last_q;

  // Control
  logic                     in_acc;
  logic                     out_free;
  logic                     rd_en;
  logic [AddrW-1:0]         rd_addr;
  logic                     wr_en;
  logic [LMFSD_ROW_W-1:0]   wr_data;
  logic                     load_read;
  logic                     load_row;
  logic [LMFSD_ROW_W-1:0]   eff_row;
  logic [LMFSD_ROW_W-1:0]   y_bit;
  logic [LMFSD_ROW_W-1:0]   row_sel;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  // Rows never written since reset or clear read as all off
  assign eff_row  = rd_vld_q ? rd_data_q : '0;
  assign y_bit    = LMFSD_ROW_W'(1) << y_q;
  assign row_sel  = LMFSD_ROW_W'(1) << ld_row_q;
  assign wr_data  = on_q ? (eff_row | y_bit) : (eff_row & ~y_bit);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_WRITE:  state_d = ST_WRITE;
            CMD_READ:   state_d = ST_READ;
            CMD_RENDER: state_d = ST_RENDER;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_READ: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_RENDER: begin
        if (load_row && ld_row_q == LastRow) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = in_x[AddrW-1:0];
    wr_en           = 1'b0;
    load_read       = 1'b0;
    load_row        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        rd_en = s_axis_tvalid_i && (in_cmd == CMD_WRITE || in_cmd == CMD_READ);
      end
      ST_WRITE: wr_en = 1'b1;
      ST_READ:  load_read = out_free;
      ST_RENDER: begin
        load_row = pend_q && out_free;
        // Keep one row in flight; refill as the held row leaves
        if (rd_busy_q && (!pend_q || load_row)) begin
          rd_en   = 1'b1;
          rd_addr = rd_row_q;
        end
      end
      default: ;
    endcase
  end

  // Frame memory, one row per word, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[x_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Command payload capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q  <= in_x[AddrW-1:0];
      y_q  <= in_y;
      on_q <= in_on;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      rd_row_q    <= '0;
      rd_busy_q   <= 1'b0;
      pend_q      <= 1'b0;
      ld_row_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Row valid flags; clear drops them all at once
      if (in_acc && in_cmd == CMD_CLEAR) begin
        row_vld_q <= '0;
      end else if (wr_en) begin
        row_vld_q[x_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= row_vld_q[rd_addr];
      end
      // Render row counters
      if (in_acc && in_cmd == CMD_RENDER) begin
        rd_row_q  <= '0;
        rd_busy_q <= 1'b1;
        pend_q    <= 1'b0;
        ld_row_q  <= '0;
      end else if (state_q == ST_RENDER) begin
        if (rd_en) begin
          rd_row_q <= rd_row_q + AddrW'(1);
          if (rd_row_q == LastRow) rd_busy_q <= 1'b0;
          pend_q <= 1'b1;
        end else if (load_row) begin
          pend_q <= 1'b0;
        end
        if (load_row) ld_row_q <= ld_row_q + AddrW'(1);
      end
      // Output register handshake
      if (load_read || load_row) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load_read) begin
      out_kind_q <= KIND_PIXEL;
      out_pix_q  <= eff_row[y_q];
      out_row_q  <= '0;
      out_word_q <= '0;
      out_last_q <= 1'b1;
    end else if (load_row) begin
      out_kind_q <= KIND_ROW;
      out_pix_q  <= 1'b0;
      out_row_q  <= LMFSD_COORD_W'(ld_row_q);
      out_word_q <= {~row_sel, ~eff_row};
      out_last_q <= (ld_row_q == LastRow);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_word_q, out_row_q, out_pix_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

### test/lmfsd_scan_checker.sv
// Checker for the LED matrix frame scan driver: watches both streams, keeps its own
// copy of the frame, predicts each result word and compares it field by field.
// Depends on lmfsd_pkg.
`timescale 1ns / 100ps

module lmfsd_scan_checker
  import lmfsd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Command stream, observed
  input  wire logic                   s_tvalid_i,
  input  wire logic                   s_tready_i,
  // [1:0] command, [5:2] x, [9:6] y, [10] pixel_on, [15:11] zero
  input  wire logic [LMFSD_IN_W-1:0]  s_tdata_i,
  // Result stream, observed
  input  wire logic                   m_tvalid_i,
  input  wire logic                   m_tready_i,
  // [0] pixel_value, [4:1] row_index, [36:5] shift_word, [39:37] zero
  input  wire logic [LMFSD_OUT_W-1:0] m_tdata_i,
  // [0] kind
  input  wire logic                   m_tuser_i,
  input  wire logic                   m_tlast_i,
  output int                          err_count_o,
  output int                          pending_o
);

  typedef struct packed {
    lmfsd_kind_e kind;
    logic        pixel;
    logic [3:0]  row;
    logic [31:0] shift;
    logic        last;
  } scan_result_t;

  // Shadow frame: bit y of lit_rows[x] is pixel (x,y)
  logic [LMFSD_ROW_W-1:0] lit_rows [LMFSD_SIDE];
  scan_result_t           owed_results [$];
  int                     errors;

  // Field-by-field comparison of one result word
  task automatic compare_result(input scan_result_t want, input scan_result_t got);
    if (got.kind !== want.kind) begin
      $display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, got.kind);
      errors++;
    end
    if (got.pixel !== want.pixel) begin
      $display("%0t: pixel_value mismatch: expected %0d, got %0d",
               $time, want.pixel, got.pixel);
      errors++;
    end
    if (got.row !== want.row) begin
      $display("%0t: row_index mismatch: expected %0d, got %0d", $time, want.row, got.row);
      errors++;
    end
    if (got.shift !== want.shift) begin
      $display("%0t: shift_word mismatch: expected %08h, got %08h",
               $time, want.shift, got.shift);
      errors++;
    end
    if (got.last !== want.last) begin
      $display("%0t: last mismatch: expected %0d, got %0d", $time, want.last, got.last);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    scan_result_t want;
    scan_result_t got;
    lmfsd_cmd_e   cmd;
    logic [3:0]   px;
    logic [3:0]   py;
    if (!rst_ni) begin
      for (int r = 0; r < LMFSD_SIDE; r++) lit_rows[r] = '0;
      owed_results.delete();
      errors = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      // Result side: match against the oldest owed word
      if (m_tvalid_i && m_tready_i) begin
        got.kind  = lmfsd_kind_e'(m_tuser_i);
        got.pixel = m_tdata_i[0];
        got.row   = m_tdata_i[4:1];
        got.shift = m_tdata_i[36:5];
        got.last  = m_tlast_i;
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %010h last %0d",
                   $time, m_tdata_i, m_tlast_i);
          errors++;
        end else begin
          want = owed_results.pop_front();
          compare_result(want, got);
        end
      end

      // Command side: update the shadow frame and queue what is owed
      if (s_tvalid_i && s_tready_i) begin
        cmd = lmfsd_cmd_e'(s_tdata_i[1:0]);
        px  = s_tdata_i[5:2];
        py  = s_tdata_i[9:6];
        case (cmd)
          CMD_WRITE: begin
            lit_rows[px][py] = s_tdata_i[10];
          end
          CMD_READ: begin
            want.kind  = KIND_PIXEL;
            want.pixel = lit_rows[px][py];
            want.row   = '0;
            want.shift = '0;
            want.last  = 1'b1;
            owed_results.push_back(want);
          end
          CMD_CLEAR: begin
            for (int r = 0; r < LMFSD_SIDE; r++) lit_rows[r] = '0;
          end
          default: begin
            // render: active-low row select over inverted pixels
            for (int r = 0; r < LMFSD_SIDE; r++) begin
              want.kind  = KIND_ROW;
              want.pixel = 1'b0;
              want.row   = r[3:0];
              want.shift = {~(16'd1 << r), ~lit_rows[r]};
              want.last  = (r == LMFSD_SIDE - 1);
              owed_results.push_back(want);
            end
          end
        endcase
      end

      err_count_o <= errors;
      pending_o   <= owed_results.size();
    end
  end

endmodule

### test/tb_led_matrix_frame_scan_driver_core.sv
// Top of the LED matrix frame scan driver testbench: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict. Checking is done in lmfsd_scan_checker.
// Depends on lmfsd_pkg, led_matrix_frame_scan_driver_core and lmfsd_scan_checker.
`timescale 1ns / 100ps

module tb_led_matrix_frame_scan_driver_core;
  import lmfsd_pkg::*;

  localparam int RandomCmds  = 330;
  localparam int QuietTail   = 60;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 20;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [LMFSD_IN_W-1:0]  s_data = '0;
  logic                   m_valid;
  logic                   m_ready = 1'b1;
  logic [LMFSD_OUT_W-1:0] m_data;
  logic                   m_user;
  logic                   m_last;
  int                     err_count;
  int                     words_owed;
  int                     idle_cycles = 0;
  bit                     pace_on = 1'b1;

  always #4 clk_i = ~clk_i;

  led_matrix_frame_scan_driver_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  lmfsd_scan_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_valid),
    .s_tready_i  (s_ready),
    .s_tdata_i   (s_data),
    .m_tvalid_i  (m_valid),
    .m_tready_i  (m_ready),
    .m_tdata_i   (m_data),
    .m_tuser_i   (m_user),
    .m_tlast_i   (m_last),
    .err_count_o (err_count),
    .pending_o   (words_owed)
  );

  // Result back-pressure: random stalls while pacing is on
  initial begin : sink_pacing
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (pace_on && $urandom_range(0, 4) == 0) begin
        m_ready = 1'b0;
        hold    = $urandom_range(0, 8);
      end else begin
        m_ready = 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Send one command word; entered and left at a falling edge
  task automatic issue_command(input lmfsd_cmd_e cmd, input logic [3:0] x,
                               input logic [3:0] y, input logic on);
    if (pace_on && $urandom_range(0, 3) == 0) begin
      s_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = {5'd0, on, y, x, cmd};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every owed result word has come back
  task automatic wait_drained();
    s_valid = 1'b0;
    while (words_owed != 0) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int         pick;
    lmfsd_cmd_e cmd;
    logic       on;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: corner pixels, set and clear, unlit read, render, clear
    issue_command(CMD_READ,   4'd0,  4'd0,  1'b1);
    issue_command(CMD_RENDER, 4'd9,  4'd3,  1'b1);
    issue_command(CMD_WRITE,  4'd0,  4'd0,  1'b1);
    issue_command(CMD_WRITE,  4'd0,  4'd15, 1'b1);
    issue_command(CMD_WRITE,  4'd15, 4'd0,  1'b1);
    issue_command(CMD_WRITE,  4'd15, 4'd15, 1'b1);
    issue_command(CMD_WRITE,  4'd6,  4'd9,  1'b1);
    issue_command(CMD_WRITE,  4'd9,  4'd6,  1'b1);
    issue_command(CMD_WRITE,  4'd9,  4'd6,  1'b0);
    issue_command(CMD_READ,   4'd0,  4'd0,  1'b0);
    issue_command(CMD_READ,   4'd15, 4'd15, 1'b1);
    issue_command(CMD_READ,   4'd6,  4'd9,  1'b0);
    issue_command(CMD_READ,   4'd9,  4'd6,  1'b1);
    issue_command(CMD_READ,   4'd3,  4'd12, 1'b0);
    issue_command(CMD_RENDER, 4'd15, 4'd0,  1'b0);
    issue_command(CMD_CLEAR,  4'd10, 4'd5,  1'b1);
    issue_command(CMD_READ,   4'd15, 4'd0,  1'b1);
    issue_command(CMD_RENDER, 4'd0,  4'd15, 1'b1);
    issue_command(CMD_WRITE,  4'd15, 4'd15, 1'b1);
    issue_command(CMD_RENDER, 4'd5,  4'd10, 1'b0);
    wait_drained();

    // Random: mostly writes and reads so the frame fills, some renders, rare clears
    for (int n = 0; n < RandomCmds; n++) begin
      if (n == RandomCmds / 2) wait_drained();
      if (n == RandomCmds - QuietTail) pace_on = 1'b0;
      pick = $urandom_range(0, 99);
      on   = 1'($urandom_range(0, 1));
      if (pick < 48) begin
        cmd = CMD_WRITE;
        on  = ($urandom_range(0, 9) < 6);
      end else if (pick < 82) begin
        cmd = CMD_READ;
      end else if (pick < 91) begin
        cmd = CMD_RENDER;
      end else if (pick < 94) begin
        cmd = CMD_CLEAR;
      end else begin
        cmd = lmfsd_cmd_e'(2'($urandom_range(0, 3)));
      end
      issue_command(cmd, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), on);
    end
    s_valid = 1'b0;

    // Drain, then let any trailing write settle
    while (words_owed != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && words_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
